// File: hw/rtl/rse_pkg.sv
// Shared constants and types for the RISC subset executor.
`default_nettype none

package rse_pkg;

    // Storage sizes
    localparam int MEM_WORDS = 1024;
    localparam int NUM_REGS  = 32;

    // Derived index widths
    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int RF_AW  = $clog2(NUM_REGS);

    // Width of a register index field on the ports
    localparam int REG_IW = 5;

    // Request codes; code 7 is unused and has no effect
    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_LOAD    = 3'd2,
        OP_STORE   = 3'd3,
        OP_BEQ     = 3'd4,
        OP_PRELOAD = 3'd5,
        OP_READ    = 3'd6
    } t_op;

    // Register file write request
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] idx;
        logic [31:0]      data;
    } t_rf_wr;

endpackage : rse_pkg

`default_nettype wire

// File: hw/rtl/rse_rf.sv
// Register file: two registered read ports, one write port, per-entry valid bits.
`default_nettype none

module rse_rf (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic [rse_pkg::RF_AW-1:0] i_ra_idx,
    input  wire logic [rse_pkg::RF_AW-1:0] i_rb_idx,
    input  wire rse_pkg::t_rf_wr           i_wr,
    output logic [31:0]                    o_ra_data,
    output logic [31:0]                    o_rb_data
);

    logic [31:0]                  r_mem [rse_pkg::NUM_REGS];
    logic [rse_pkg::NUM_REGS-1:0] r_vld;

    logic [31:0] r_qa;
    logic [31:0] r_qb;
    logic        r_va;
    logic        r_vb;
    logic        r_hit_a;
    logic        r_hit_b;
    logic [31:0] r_wd;

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
    end

    // Registered reads; a same-edge write to the read entry wins
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_qa    <= r_mem[i_ra_idx];
            r_qb    <= r_mem[i_rb_idx];
            r_va    <= r_vld[i_ra_idx];
            r_vb    <= r_vld[i_rb_idx];
            r_hit_a <= i_wr.en && (i_wr.idx == i_ra_idx);
            r_hit_b <= i_wr.en && (i_wr.idx == i_rb_idx);
            r_wd    <= i_wr.data;
        end
    end

    assign o_ra_data = r_hit_a ? r_wd : (r_va ? r_qa : '0);
    assign o_rb_data = r_hit_b ? r_wd : (r_vb ? r_qb : '0);

endmodule : rse_rf

`default_nettype wire

// File: hw/rtl/risc_subset_executor.sv
// Top level of the RISC subset executor: pipeline, data memory and clearing pass.
`default_nettype none

// Executes one decoded instruction per item (add, sub, load, store, branch-if-equal,
// preload register, read register) against a 32-entry register file and a
// 1024-word data memory, and returns exactly one result item per input item, in
// order. Items flow through three registered steps: register file read, execute
// (ALU, address check, data memory access), and write-back into the output
// register. It accepts one item per cycle while o_stall is low; o_stall rises
// with back-pressure from i_stall and during the clearing pass. Register results
// are forwarded from the write-back step, so dependent items are not held back.
// After reset the data memory is zeroed by a clearing pass over all MEM_WORDS
// (1024) words, during which o_stall stays high. Load and store addresses are
// base register plus sign-extended offset with 32-bit wrap; an address that is
// negative or at or above MEM_WORDS sets bounds_error, returns zero and changes
// nothing. A branch only reports taken and its offset. Request code 7 changes
// nothing and returns all-zero fields.

module risc_subset_executor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [4:0]  i_dest_reg,
    input  wire logic [4:0]  i_src_reg,
    input  wire logic [4:0]  i_second_reg,
    input  wire logic signed [15:0] i_imm_offset,
    input  wire logic signed [31:0] i_preload_value,
    // result item channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_result_value,
    output logic             o_branch_taken,
    output logic signed [15:0] o_taken_offset,
    output logic             o_bounds_error
);

    localparam int MAW = rse_pkg::MEM_AW;
    localparam int RAW = rse_pkg::RF_AW;
    localparam int RIW = rse_pkg::REG_IW;

    // ---------------------------------------------------------------
    // Handshake and stage advance
    // ---------------------------------------------------------------
    logic r_clr_busy;
    logic [MAW-1:0] r_clr_addr;

    logic r_s1_vld;
    logic r_s2_vld;
    logic r_out_vld;

    logic out_free;
    logic s2_go;
    logic s2_free;
    logic s1_go;
    logic s1_free;
    logic accept;

    assign out_free = !r_out_vld || !i_stall;
    assign s2_go    = r_s2_vld && out_free;
    assign s2_free  = !r_s2_vld || out_free;
    assign s1_go    = r_s1_vld && s2_free;
    assign s1_free  = !r_s1_vld || s2_free;
    assign accept   = i_valid && s1_free && !r_clr_busy;
    assign o_stall  = !s1_free || r_clr_busy;

    // ---------------------------------------------------------------
    // Issue: register file read ports
    // ---------------------------------------------------------------
    logic [RIW-1:0] in_ia;
    logic           in_a_ok;
    logic           in_b_ok;

    // Read register uses the destination field as its source
    assign in_ia   = (i_req_type == rse_pkg::OP_READ) ? i_dest_reg : i_src_reg;
    assign in_a_ok = ({1'b0, in_ia} < (RIW+1)'(rse_pkg::NUM_REGS));
    assign in_b_ok = ({1'b0, i_second_reg} < (RIW+1)'(rse_pkg::NUM_REGS));

    rse_pkg::t_rf_wr rf_wr;
    logic [31:0]     rf_a;
    logic [31:0]     rf_b;

    rse_rf u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_ra_idx  (in_ia[RAW-1:0]),
        .i_rb_idx  (i_second_reg[RAW-1:0]),
        .i_wr      (rf_wr),
        .o_ra_data (rf_a),
        .o_rb_data (rf_b)
    );

    // ---------------------------------------------------------------
    // Execute step registers
    // ---------------------------------------------------------------
    logic [2:0]     r_s1_op;
    logic [RIW-1:0] r_s1_dest;
    logic [RIW-1:0] r_s1_rt;
    logic [RIW-1:0] r_s1_ia;
    logic           r_s1_a_ok;
    logic           r_s1_b_ok;
    logic [15:0]    r_s1_imm;
    logic [31:0]    r_s1_pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= i_req_type;
            r_s1_dest <= i_dest_reg;
            r_s1_rt   <= i_second_reg;
            r_s1_ia   <= in_ia;
            r_s1_a_ok <= in_a_ok;
            r_s1_b_ok <= in_b_ok;
            r_s1_imm  <= i_imm_offset;
            r_s1_pre  <= i_preload_value;
        end
    end

    // Write-back step registers
    logic           r_s2_wb_en;
    logic [RIW-1:0] r_s2_wb_idx;
    logic           r_s2_is_load;
    logic [31:0]    r_s2_value;
    logic           r_s2_taken;
    logic [15:0]    r_s2_boff;
    logic           r_s2_err;

    logic [31:0] r_dm_q;
    logic [31:0] s2_wb_data;

    // A load returns the data memory word; everything else its own value
    assign s2_wb_data = r_s2_is_load ? r_dm_q : r_s2_value;

    // ---------------------------------------------------------------
    // Execute: forwarding, ALU, address check
    // ---------------------------------------------------------------
    logic [31:0]    op_a;
    logic [31:0]    op_b;
    logic [31:0]    addr;
    logic           addr_ok;
    logic           n_s2_wb_en;
    logic [RIW-1:0] n_s2_wb_idx;
    logic           n_s2_is_load;
    logic           n_s2_is_store;
    logic [31:0]    n_s2_value;
    logic           n_s2_taken;
    logic [15:0]    n_s2_boff;
    logic           n_s2_err;

    always_comb begin
        // Older item in write-back has not reached the register file yet
        if (!r_s1_a_ok) begin
            op_a = '0;
        end else if (r_s2_vld && r_s2_wb_en && (r_s2_wb_idx == r_s1_ia)) begin
            op_a = s2_wb_data;
        end else begin
            op_a = rf_a;
        end
        if (!r_s1_b_ok) begin
            op_b = '0;
        end else if (r_s2_vld && r_s2_wb_en && (r_s2_wb_idx == r_s1_rt)) begin
            op_b = s2_wb_data;
        end else begin
            op_b = rf_b;
        end
    end

    assign addr    = op_a + {{16{r_s1_imm[15]}}, r_s1_imm};
    assign addr_ok = (addr < 32'(rse_pkg::MEM_WORDS));

    always_comb begin
        n_s2_wb_en    = 1'b0;
        n_s2_wb_idx   = r_s1_dest;
        n_s2_is_load  = 1'b0;
        n_s2_is_store = 1'b0;
        n_s2_value    = '0;
        n_s2_taken    = 1'b0;
        n_s2_boff     = '0;
        n_s2_err      = 1'b0;
        case (r_s1_op)
            rse_pkg::OP_ADD: begin
                n_s2_value = op_a + op_b;
                n_s2_wb_en = 1'b1;
            end
            rse_pkg::OP_SUB: begin
                n_s2_value = op_a - op_b;
                n_s2_wb_en = 1'b1;
            end
            rse_pkg::OP_LOAD: begin
                n_s2_wb_idx  = r_s1_rt;
                n_s2_wb_en   = addr_ok;
                n_s2_is_load = addr_ok;
                n_s2_err     = !addr_ok;
            end
            rse_pkg::OP_STORE: begin
                n_s2_is_store = addr_ok;
                n_s2_value    = addr_ok ? op_b : '0;
                n_s2_err      = !addr_ok;
            end
            rse_pkg::OP_BEQ: begin
                n_s2_taken = (op_a == op_b);
                n_s2_boff  = (op_a == op_b) ? r_s1_imm : '0;
            end
            rse_pkg::OP_PRELOAD: begin
                n_s2_value = r_s1_pre;
                n_s2_wb_en = 1'b1;
            end
            rse_pkg::OP_READ: begin
                n_s2_value = op_a;
            end
            default: begin
                n_s2_wb_en = 1'b0;
            end
        endcase
        // Writes beyond the register file are dropped
        if ({1'b0, n_s2_wb_idx} >= (RIW+1)'(rse_pkg::NUM_REGS)) begin
            n_s2_wb_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_free) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_wb_en   <= n_s2_wb_en;
            r_s2_wb_idx  <= n_s2_wb_idx;
            r_s2_is_load <= n_s2_is_load;
            r_s2_value   <= n_s2_value;
            r_s2_taken   <= n_s2_taken;
            r_s2_boff    <= n_s2_boff;
            r_s2_err     <= n_s2_err;
        end
    end

    // ---------------------------------------------------------------
    // Data memory with clearing pass after reset
    // ---------------------------------------------------------------
    logic [31:0]    r_dmem [rse_pkg::MEM_WORDS];
    logic           dm_we;
    logic           dm_re;
    logic [MAW-1:0] dm_waddr;
    logic [31:0]    dm_wdata;

    assign dm_we    = r_clr_busy || (s1_go && n_s2_is_store);
    assign dm_re    = s1_go && n_s2_is_load;
    assign dm_waddr = r_clr_busy ? r_clr_addr : addr[MAW-1:0];
    assign dm_wdata = r_clr_busy ? '0 : op_b;

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dmem[dm_waddr] <= dm_wdata;
        end
        if (dm_re) begin
            r_dm_q <= r_dmem[addr[MAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == MAW'(rse_pkg::MEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + MAW'(1);
        end
    end

    // ---------------------------------------------------------------
    // Write-back: register file update and output register
    // ---------------------------------------------------------------
    always_comb begin
        rf_wr.en   = s2_go && r_s2_wb_en;
        rf_wr.idx  = r_s2_wb_idx[RAW-1:0];
        rf_wr.data = s2_wb_data;
    end

    logic [31:0] r_out_value;
    logic        r_out_taken;
    logic [15:0] r_out_boff;
    logic        r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out_value <= s2_wb_data;
            r_out_taken <= r_s2_taken;
            r_out_boff  <= r_s2_boff;
            r_out_err   <= r_s2_err;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_result_value  = r_out_value;
    assign o_branch_taken  = r_out_taken;
    assign o_taken_offset  = r_out_boff;
    assign o_bounds_error  = r_out_err;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_vld && !r_s2_vld && !r_out_vld))
        else $error("items in flight during memory clear");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted item missing from execute step");

    a_wb_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_wb_en) |->
        ({1'b0, r_s2_wb_idx} < (RIW+1)'(rse_pkg::NUM_REGS)))
        else $error("register write beyond register file");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_err) |-> (r_out_value == '0 && !r_out_taken))
        else $error("bounds error with nonzero result");

    a_load_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dm_re && dm_we))
        else $error("data memory read and write in the same cycle");

endmodule : risc_subset_executor

`default_nettype wire

// File: test/tb_risc_subset_executor.sv
// Self-checking testbench for the RISC subset executor.
module tb_risc_subset_executor;
    timeunit 1ns;
    timeprecision 1ps;

    // Request code 7 has no enum member: no effect, all-zero result
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // One decoded instruction, as driven on the input ports
    typedef struct packed {
        logic [2:0]  req;
        logic [4:0]  rd;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic [31:0] pre;
    } t_instr;

    // One result item, as seen on the output ports
    typedef struct packed {
        logic [31:0] value;
        logic        taken;
        logic [15:0] boff;
        logic        err;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_req_type;
    logic [4:0]  i_dest_reg;
    logic [4:0]  i_src_reg;
    logic [4:0]  i_second_reg;
    logic [15:0] i_imm_offset;
    logic [31:0] i_preload_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result_value;
    logic        o_branch_taken;
    logic [15:0] o_taken_offset;
    logic        o_bounds_error;

    risc_subset_executor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_dest_reg      (i_dest_reg),
        .i_src_reg       (i_src_reg),
        .i_second_reg    (i_second_reg),
        .i_imm_offset    (i_imm_offset),
        .i_preload_value (i_preload_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_value  (o_result_value),
        .o_branch_taken  (o_branch_taken),
        .o_taken_offset  (o_taken_offset),
        .o_bounds_error  (o_bounds_error)
    );

    // Shadow copies of the register file and data memory, updated on accept
    logic [31:0] rf_shadow  [rse_pkg::NUM_REGS];
    logic [31:0] mem_shadow [rse_pkg::MEM_WORDS];

    // Results predicted for accepted items, oldest first
    t_outcome pending_results [$];
    t_outcome want_now;
    int       mismatch_count;
    // Random idling on both channels; cleared for the last part of the run
    bit       idle_on;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard limit: 2 ms of simulated time, far beyond the slowest legal run including
    // the memory clearing pass.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Indexes at or above NUM_REGS read as zero and ignore writes
    function automatic logic [31:0] rf_get(logic [4:0] idx);
        return (idx < rse_pkg::NUM_REGS) ? rf_shadow[idx] : 32'h0;
    endfunction

    function automatic void rf_put(logic [4:0] idx, logic [31:0] val);
        if (idx < rse_pkg::NUM_REGS) rf_shadow[idx] = val;
    endfunction

    // Applies one instruction to the shadow state and returns its result
    function automatic t_outcome execute_instr(t_instr it);
        t_outcome    res;
        logic [31:0] addr;
        logic        in_mem;
        res = '0;
        // base + sign-extended offset, 32-bit wrap; negative wraps high and fails
        addr   = rf_get(it.rs) + {{16{it.imm[15]}}, it.imm};
        in_mem = (addr < 32'(rse_pkg::MEM_WORDS));
        case (it.req)
            rse_pkg::OP_ADD: begin
                res.value = rf_get(it.rs) + rf_get(it.rt);
                rf_put(it.rd, res.value);
            end
            rse_pkg::OP_SUB: begin
                res.value = rf_get(it.rs) - rf_get(it.rt);
                rf_put(it.rd, res.value);
            end
            rse_pkg::OP_LOAD: begin
                if (in_mem) begin
                    res.value = mem_shadow[addr[rse_pkg::MEM_AW-1:0]];
                    rf_put(it.rt, res.value);
                end else begin
                    res.err = 1'b1;
                end
            end
            rse_pkg::OP_STORE: begin
                if (in_mem) begin
                    res.value = rf_get(it.rt);
                    mem_shadow[addr[rse_pkg::MEM_AW-1:0]] = res.value;
                end else begin
                    res.err = 1'b1;
                end
            end
            rse_pkg::OP_BEQ: begin
                if (rf_get(it.rs) == rf_get(it.rt)) begin
                    res.taken = 1'b1;
                    res.boff  = it.imm;
                end
            end
            rse_pkg::OP_PRELOAD: begin
                res.value = it.pre;
                rf_put(it.rd, res.value);
            end
            rse_pkg::OP_READ: res.value = rf_get(it.rd);
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_instr mk(logic [2:0] req, logic [4:0] rd, logic [4:0] rs,
                                  logic [4:0] rt, logic [15:0] imm, logic [31:0] pre);
        t_instr it;
        it.req = req;
        it.rd  = rd;
        it.rs  = rs;
        it.rt  = rt;
        it.imm = imm;
        it.pre = pre;
        return it;
    endfunction

    // Random instruction; load/store offsets are steered from the shadow
    // state so most addresses land in (or just outside) the memory.
    function automatic t_instr rand_item();
        t_instr it;
        int     pick;
        int     target;
        longint diff;
        it.rd  = 5'($urandom_range(0, 31));
        it.rs  = 5'($urandom_range(0, 31));
        it.rt  = 5'($urandom_range(0, 31));
        it.imm = 16'($urandom);
        it.pre = $urandom;
        pick   = $urandom_range(0, 99);
        if (pick < 12)      it.req = rse_pkg::OP_ADD;
        else if (pick < 22) it.req = rse_pkg::OP_SUB;
        else if (pick < 40) it.req = rse_pkg::OP_LOAD;
        else if (pick < 60) it.req = rse_pkg::OP_STORE;
        else if (pick < 72) it.req = rse_pkg::OP_BEQ;
        else if (pick < 86) it.req = rse_pkg::OP_PRELOAD;
        else if (pick < 96) it.req = rse_pkg::OP_READ;
        else                it.req = REQ_UNUSED;

        case (it.req)
            rse_pkg::OP_PRELOAD: begin
                // Half the preloads make usable base registers
                case ($urandom_range(0, 5))
                    0, 1, 2: it.pre = 32'(int'($urandom_range(0, rse_pkg::MEM_WORDS + 64))
                                          - 32);
                    3: begin
                        case ($urandom_range(0, 3))
                            0: it.pre = 32'h8000_0000;
                            1: it.pre = 32'h7fff_ffff;
                            2: it.pre = 32'h0;
                            default: it.pre = 32'hffff_ffff;
                        endcase
                    end
                    default: ;
                endcase
            end
            rse_pkg::OP_LOAD, rse_pkg::OP_STORE: begin
                // prefer a base whose value an offset can reach
                repeat (4) begin
                    if ($signed(rf_shadow[it.rs]) < -30000 ||
                        $signed(rf_shadow[it.rs]) > 30000)
                        it.rs = 5'($urandom_range(0, 31));
                end
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1, 2, 3, 4: target = $urandom_range(0, 15);
                    5, 6: target = $urandom_range(0, rse_pkg::MEM_WORDS - 1);
                    7: target = $urandom_range(0, 1) ? 0 : rse_pkg::MEM_WORDS - 1;
                    8: target = $urandom_range(0, 1) ? -1 - int'($urandom_range(0, 3))
                                : rse_pkg::MEM_WORDS + int'($urandom_range(0, 3));
                    default: target = 0;
                endcase
                if (pick != 9) begin
                    diff = longint'(target) - longint'($signed(rf_shadow[it.rs]));
                    if (diff >= -32768 && diff <= 32767) it.imm = diff[15:0];
                end
            end
            rse_pkg::OP_BEQ: begin
                if ($urandom_range(0, 2) == 0) it.rt = it.rs;
                if ($urandom_range(0, 7) == 0) it.imm = 16'h0;
            end
            default: ;
        endcase
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with i_valid still high, so the next item can follow back to back.
    task automatic send_item(t_instr it);
        bit taken;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_req_type      <= it.req;
        i_dest_reg      <= it.rd;
        i_src_reg       <= it.rs;
        i_second_reg    <= it.rt;
        i_imm_offset    <= it.imm;
        i_preload_value <= it.pre;
        i_valid         <= 1'b1;
        do begin
            @(posedge i_clk);
            taken = !o_stall;
            if (taken) pending_results.push_back(execute_instr(it));
            @(negedge i_clk);
        end while (!taken);
    endtask

    // Sender stops until every predicted result has come back
    task automatic wait_all_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, every operation and the special cases
    task automatic test_directed();
        // reset state: registers and memory read zero
        send_item(mk(rse_pkg::OP_READ,    5'd0,  5'd0,  5'd0,  16'h0, 32'h0));
        send_item(mk(rse_pkg::OP_READ,    5'd31, 5'd0,  5'd0,  16'h0, 32'h0));
        send_item(mk(rse_pkg::OP_LOAD,    5'd0,  5'd0,  5'd9,  16'h0, 32'h0));
        // preload extremes; register 0 is writable
        send_item(mk(rse_pkg::OP_PRELOAD, 5'd1,  5'd0,  5'd0,  16'h0, 32'h7fff_ffff));
        send_item(mk(rse_pkg::OP_PRELOAD, 5'd2,  5'd0,  5'd0,  16'h0, 32'h8000_0000));
        send_item(mk(rse_pkg::OP_PRELOAD, 5'd3,  5'd0,  5'd0,  16'h0, 32'hffff_ffff));
        send_item(mk(rse_pkg::OP_PRELOAD, 5'd31, 5'd0,  5'd0,  16'h0,
                     32'(rse_pkg::MEM_WORDS - 1)));
        send_item(mk(rse_pkg::OP_PRELOAD, 5'd0,  5'd0,  5'd0,  16'h0, 32'd5));
        // wrapping arithmetic
        send_item(mk(rse_pkg::OP_ADD,     5'd4,  5'd1,  5'd3,  16'h0, 32'h0));
        send_item(mk(rse_pkg::OP_ADD,     5'd5,  5'd1,  5'd1,  16'h0, 32'h0));
        send_item(mk(rse_pkg::OP_SUB,     5'd6,  5'd2,  5'd1,  16'h0, 32'h0));
        send_item(mk(rse_pkg::OP_SUB,     5'd7,  5'd0,  5'd0,  16'h0, 32'h0));
        // last word, one past it, word 0, below word 0, negative base
        send_item(mk(rse_pkg::OP_STORE,   5'd0,  5'd31, 5'd1,  16'h0, 32'h0));
        send_item(mk(rse_pkg::OP_LOAD,    5'd0,  5'd31, 5'd8,  16'h0, 32'h0));
        send_item(mk(rse_pkg::OP_STORE,   5'd0,  5'd31, 5'd1,  16'h1, 32'h0));
        send_item(mk(rse_pkg::OP_STORE,   5'd0,  5'd0,  5'd2,  -16'sd5, 32'h0));
        send_item(mk(rse_pkg::OP_LOAD,    5'd0,  5'd0,  5'd11, -16'sd6, 32'h0));
        send_item(mk(rse_pkg::OP_LOAD,    5'd0,  5'd2,  5'd11, 16'h0, 32'h0));
        // offset extremes
        send_item(mk(rse_pkg::OP_LOAD,    5'd0,  5'd31, 5'd11, 16'h8000, 32'h0));
        send_item(mk(rse_pkg::OP_STORE,   5'd0,  5'd0,  5'd1,  16'h7fff, 32'h0));
        send_item(mk(rse_pkg::OP_LOAD,    5'd0,  5'd31, 5'd10, -16'sd1023, 32'h0));
        // branch: taken with zero offset, not taken, offset extremes
        send_item(mk(rse_pkg::OP_BEQ,     5'd0,  5'd1,  5'd1,  16'h0, 32'h0));
        send_item(mk(rse_pkg::OP_BEQ,     5'd0,  5'd1,  5'd2,  16'h5, 32'h0));
        send_item(mk(rse_pkg::OP_BEQ,     5'd0,  5'd7,  5'd7,  16'h8000, 32'h0));
        send_item(mk(rse_pkg::OP_BEQ,     5'd0,  5'd3,  5'd3,  16'h7fff, 32'h0));
        send_item(mk(rse_pkg::OP_READ,    5'd10, 5'd0,  5'd0,  16'h0, 32'h0));
        // unused code with every field at all ones
        send_item(mk(REQ_UNUSED, 5'd31, 5'd31, 5'd31, 16'hffff, 32'hffff_ffff));
    endtask

    // preload base and data, store, load it back elsewhere, read the copy
    task automatic mem_roundtrip();
        logic [4:0]  base;
        logic [4:0]  data;
        logic [4:0]  dst;
        int          addr;
        int          off;
        base = 5'($urandom_range(0, 31));
        data = 5'($urandom_range(0, 31));
        dst  = 5'($urandom_range(0, 31));
        addr = $urandom_range(0, rse_pkg::MEM_WORDS - 1);
        off  = int'($urandom_range(0, 64)) - 32;
        send_item(mk(rse_pkg::OP_PRELOAD, data, 5'd0, 5'd0, 16'h0, $urandom));
        send_item(mk(rse_pkg::OP_PRELOAD, base, 5'd0, 5'd0, 16'h0, 32'(addr - off)));
        send_item(mk(rse_pkg::OP_STORE, 5'd0, base, data, off[15:0], 32'h0));
        send_item(mk(rse_pkg::OP_LOAD, 5'd0, base, dst, off[15:0], 32'h0));
        send_item(mk(rse_pkg::OP_READ, dst, 5'd0, 5'd0, 16'h0, 32'h0));
    endtask

    // Random mix with idling switched off for some stretches
    task automatic test_random_mix(int count);
        int sent;
        int block;
        sent  = 0;
        block = 0;
        while (sent < count) begin
            if (sent / 100 != block) begin
                block   = sent / 100;
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 11) == 0) begin
                mem_roundtrip();
                sent += 5;
            end else begin
                send_item(rand_item());
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    // Sender holds off until the pipeline is empty, then resumes
    task automatic test_drain_pause();
        repeat (100) send_item(rand_item());
        wait_all_results();
        repeat (200) send_item(rand_item());
    endtask

    // Last part: no idling on either side
    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (600) send_item(rand_item());
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Result receiver: stall in random bursts while idling is on
    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && idle_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result item", o_result_value, 32'h0);
            end else begin
                want_now = pending_results.pop_front();
                if (o_result_value !== want_now.value)
                    report_mismatch("result_value", o_result_value, want_now.value);
                if (o_branch_taken !== want_now.taken)
                    report_mismatch("branch_taken", 32'(o_branch_taken), 32'(want_now.taken));
                if (o_taken_offset !== want_now.boff)
                    report_mismatch("taken_offset", 32'(o_taken_offset),
                                    32'(want_now.boff));
                if (o_bounds_error !== want_now.err)
                    report_mismatch("bounds_error", 32'(o_bounds_error), 32'(want_now.err));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_req_type      = '0;
        i_dest_reg      = '0;
        i_src_reg       = '0;
        i_second_reg    = '0;
        i_imm_offset    = '0;
        i_preload_value = '0;
        idle_on         = 1'b1;
        mismatch_count  = 0;
        foreach (rf_shadow[k])  rf_shadow[k]  = 32'h0;
        foreach (mem_shadow[k]) mem_shadow[k] = 32'h0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the memory clearing pass holds o_stall high; send_item waits it out
        @(negedge i_clk);

        test_directed();
        test_random_mix(1000);
        test_drain_pause();
        test_no_idle();

        wait_all_results();
        // keep watching for stray results after the last expected one
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
